FILE: rtl/dthp_pkg.sv
package dthp_pkg;

  localparam int unsigned MAX_LENGTH_BYTES_DEF = 8;
  localparam int unsigned LEN_CNT_W            = 4;
  localparam logic [31:0] MAX_PRIM_LEN_RST     = 32'd16384;

  // One bit per universal tag number that the parser accepts:
  // 1..6, 12, 16, 19, 22, 23.
  localparam logic [31:0] SUPPORTED_MASK = 32'h00C9_107E;
  localparam logic [4:0]  TAG_LIMIT      = 5'd24;
  localparam logic [63:0] TAG_SEQ        = 64'd16;
  localparam logic [63:0] TAG_SETOF      = 64'd17;

  localparam logic [4:0] TAG_LONG_FORM = 5'h1f;

  typedef enum logic [3:0] {
    PH_FIRST    = 4'b0001,
    PH_TAGMORE  = 4'b0010,
    PH_LENFIRST = 4'b0100,
    PH_LENMORE  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TRUNC_TAG   = 3'd1,
    ST_UNSUP_TAG   = 3'd2,
    ST_MISSING_LEN = 3'd3,
    ST_TRUNC_LEN   = 3'd4,
    ST_LEN_OF_LEN  = 3'd5,
    ST_INDEF_PRIM  = 3'd6,
    ST_LEN_LARGE   = 3'd7
  } status_t;

endpackage

FILE: rtl/der_tlv_header_parser.sv
// DER identifier/length header parser.
// Result: out_valid rises in the cycle after the word that ends
// the header (or the failing word) is accepted.
// Throughput: one word per cycle; in_ready drops only while a result waits
// in the output register and out_ready is low.
// Reset (rst_n low, synchronous): first tag byte expected, no result, limit 16384.
module der_tlv_header_parser #(
  parameter int unsigned MAX_LENGTH_BYTES = dthp_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_max_primitive_length,
  // byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_header_byte,
  input  logic [31:0] in_bytes_left,
  // header results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [1:0]  out_class_out,
  output logic        out_is_constructed,
  output logic [4:0]  out_tag_number,
  output logic [63:0] out_content_length,
  output logic        out_is_indefinite
);

  // Parser state
  dthp_pkg::phase_t                    phase_r, phase_nxt;
  logic [63:0]                         tag_accum_r, tag_accum_nxt;
  logic [1:0]                          class_r, class_nxt;
  logic                                cons_r, cons_nxt;
  logic [dthp_pkg::LEN_CNT_W-1:0]      len_pend_r, len_pend_nxt;
  logic [63:0]                         len_accum_r, len_accum_nxt;
  logic [31:0]                         max_prim_r;

  // Output register
  logic                                out_valid_r, out_valid_nxt;
  dthp_pkg::status_t                   out_status_r;
  logic [1:0]                          out_class_r;
  logic                                out_cons_r;
  logic [4:0]                          out_tag_r;
  logic [63:0]                         out_len_r;
  logic                                out_indef_r;

  // Result of the current word
  logic                                emit;
  dthp_pkg::status_t                   emit_status;
  logic [4:0]                          emit_tag;
  logic [63:0]                         emit_len;
  logic                                emit_indef;

  logic                                in_fire;
  logic                                left_zero;
  logic [63:0]                         tag_cand;
  logic                                tag_ok;
  logic [63:0]                         len_cand;
  logic                                seq_or_set;
  logic                                len_too_big;
  logic [6:0]                          lol;
  logic [dthp_pkg::LEN_CNT_W-1:0]      len_pend_dec;

  assign cfg_ready = 1'b1;
  // Take a new word whenever the output register is free or being drained.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign left_zero = (in_bytes_left == 32'd0);

  // Candidate tag: short form from the first byte, else shift in 7 bits.
  assign tag_cand = (phase_r == dthp_pkg::PH_FIRST) ? {59'd0, in_header_byte[4:0]}
                                                    : {tag_accum_r[56:0], in_header_byte[6:0]};
  assign tag_ok   = !(|tag_cand[63:5]) && (tag_cand[4:0] < dthp_pkg::TAG_LIMIT) &&
                    dthp_pkg::SUPPORTED_MASK[tag_cand[4:0]];

  // Candidate length: short form from the first length byte, else shift in a byte.
  assign len_cand   = (phase_r == dthp_pkg::PH_LENFIRST) ? {56'd0, in_header_byte}
                                                        : {len_accum_r[55:0], in_header_byte};
  assign seq_or_set = (tag_accum_r == dthp_pkg::TAG_SEQ) || (tag_accum_r == dthp_pkg::TAG_SETOF);
  assign len_too_big = (|len_cand[63:32]) || (len_cand[31:0] > in_bytes_left) ||
                       (!seq_or_set && (len_cand > {32'd0, max_prim_r}));

  assign lol          = in_header_byte[6:0];
  assign len_pend_dec = len_pend_r - dthp_pkg::LEN_CNT_W'(len_pend_r != '0);

  always_comb begin
    phase_nxt     = phase_r;
    tag_accum_nxt = tag_accum_r;
    class_nxt     = class_r;
    cons_nxt      = cons_r;
    len_pend_nxt  = len_pend_r;
    len_accum_nxt = len_accum_r;
    emit          = 1'b0;
    emit_status   = dthp_pkg::ST_OK;
    emit_tag      = tag_accum_r[4:0];
    emit_len      = 64'd0;
    emit_indef    = 1'b0;

    unique case (phase_r)
      dthp_pkg::PH_FIRST: begin
        class_nxt = in_header_byte[7:6];
        cons_nxt  = in_header_byte[5];
        if (in_header_byte[4:0] == dthp_pkg::TAG_LONG_FORM) begin
          tag_accum_nxt = 64'd0;
          if (left_zero) begin
            emit        = 1'b1;
            emit_status = dthp_pkg::ST_TRUNC_TAG;
            emit_tag    = 5'd0;
          end else begin
            phase_nxt = dthp_pkg::PH_TAGMORE;
          end
        end else begin
          tag_accum_nxt = tag_cand;
          if (!tag_ok) begin
            emit        = 1'b1;
            emit_status = dthp_pkg::ST_UNSUP_TAG;
            emit_tag    = 5'd0;
          end else if (left_zero) begin
            emit        = 1'b1;
            emit_status = dthp_pkg::ST_MISSING_LEN;
            emit_tag    = tag_cand[4:0];
          end else begin
            phase_nxt = dthp_pkg::PH_LENFIRST;
          end
        end
      end

      dthp_pkg::PH_TAGMORE: begin
        tag_accum_nxt = tag_cand;
        if (in_header_byte[7]) begin
          // continuation byte
          if (left_zero) begin
            emit        = 1'b1;
            emit_status = dthp_pkg::ST_TRUNC_TAG;
            emit_tag    = 5'd0;
          end
        end else if (!tag_ok) begin
          emit        = 1'b1;
          emit_status = dthp_pkg::ST_UNSUP_TAG;
          emit_tag    = 5'd0;
        end else if (left_zero) begin
          emit        = 1'b1;
          emit_status = dthp_pkg::ST_MISSING_LEN;
          emit_tag    = tag_cand[4:0];
        end else begin
          phase_nxt = dthp_pkg::PH_LENFIRST;
        end
      end

      dthp_pkg::PH_LENFIRST: begin
        if (in_header_byte[7]) begin
          if (lol == 7'd0) begin
            emit = 1'b1;
            if (!cons_r) begin
              emit_status = dthp_pkg::ST_INDEF_PRIM;
            end else begin
              emit_status = dthp_pkg::ST_OK;
              emit_indef  = 1'b1;
            end
          end else if (lol > 7'(MAX_LENGTH_BYTES)) begin
            emit        = 1'b1;
            emit_status = dthp_pkg::ST_LEN_OF_LEN;
          end else if (left_zero) begin
            emit        = 1'b1;
            emit_status = dthp_pkg::ST_TRUNC_LEN;
          end else begin
            len_pend_nxt  = lol[dthp_pkg::LEN_CNT_W-1:0];
            len_accum_nxt = 64'd0;
            phase_nxt     = dthp_pkg::PH_LENMORE;
          end
        end else begin
          emit = 1'b1;
          if (len_too_big) begin
            emit_status = dthp_pkg::ST_LEN_LARGE;
          end else begin
            emit_status = dthp_pkg::ST_OK;
            emit_len    = len_cand;
          end
        end
      end

      dthp_pkg::PH_LENMORE: begin
        len_accum_nxt = len_cand;
        len_pend_nxt  = len_pend_dec;
        if (len_pend_dec != '0) begin
          if (left_zero) begin
            emit        = 1'b1;
            emit_status = dthp_pkg::ST_TRUNC_LEN;
          end
        end else begin
          emit = 1'b1;
          if (len_too_big) begin
            emit_status = dthp_pkg::ST_LEN_LARGE;
          end else begin
            emit_status = dthp_pkg::ST_OK;
            emit_len    = len_cand;
          end
        end
      end

      default: begin
        phase_nxt = dthp_pkg::PH_FIRST;
      end
    endcase

    // Any result ends the header: go back to expecting a first tag byte.
    if (emit) begin
      phase_nxt    = dthp_pkg::PH_FIRST;
      len_pend_nxt = '0;
    end

    // Output register: load on a result, drop once taken, else hold.
    if (in_fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dthp_pkg::PH_FIRST;
      tag_accum_r <= 64'd0;
      class_r     <= 2'd0;
      cons_r      <= 1'b0;
      len_pend_r  <= '0;
      len_accum_r <= 64'd0;
      max_prim_r  <= dthp_pkg::MAX_PRIM_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        tag_accum_r <= tag_accum_nxt;
        class_r     <= class_nxt;
        cons_r      <= cons_nxt;
        len_pend_r  <= len_pend_nxt;
        len_accum_r <= len_accum_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        max_prim_r <= cfg_max_primitive_length;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: no reset needed, qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_status_r <= emit_status;
      out_class_r  <= class_nxt;
      out_cons_r   <= cons_nxt;
      out_tag_r    <= emit_tag;
      out_len_r    <= emit_len;
      out_indef_r  <= emit_indef;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_class_out      = out_class_r;
  assign out_is_constructed = out_cons_r;
  assign out_tag_number     = out_tag_r;
  assign out_content_length = out_len_r;
  assign out_is_indefinite  = out_indef_r;

endmodule

FILE: rtl/dthp_chk.sv
module dthp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic        out_is_constructed,
  input logic [4:0]  out_tag_number,
  input logic [63:0] out_content_length,
  input logic        out_is_indefinite
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_content_length) && $stable(out_tag_number))
    else $error("stalled result changed");

  // Input stalls only while a result waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output occupancy");

  // Indefinite form only on a good constructed header with zero length.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_indefinite |->
      out_status == dthp_pkg::ST_OK && out_is_constructed && out_content_length == 64'd0)
    else $error("bad indefinite result");

  // Errors carry no length.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dthp_pkg::ST_OK |->
      out_content_length == 64'd0 && !out_is_indefinite)
    else $error("error result carries a length");

  // Tag errors carry no tag number.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dthp_pkg::ST_TRUNC_TAG ||
                  out_status == dthp_pkg::ST_UNSUP_TAG) |-> out_tag_number == 5'd0)
    else $error("tag error carries a tag number");

endmodule

bind der_tlv_header_parser dthp_chk u_dthp_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_is_constructed (out_is_constructed),
  .out_tag_number     (out_tag_number),
  .out_content_length (out_content_length),
  .out_is_indefinite  (out_is_indefinite)
);
